// ===== sv/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the servo position PID drive
// Beat layouts of both channels, register indexes, reset values and the
// constants of the duty scaling path.
// ----------------------------------------------------------------------------
package spd_pkg;

   // Fixed-point fraction bits of setpoint and velocity
   localparam int FRACTION_BITS_DEFAULT = 32;

   // Register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUTY_MAX       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REVERSED       = 3'd5;

   // Register reset values
   localparam logic [15:0] GAIN_P_RESET         = 16'd160;
   localparam logic [15:0] GAIN_I_RESET         = 16'd2;
   localparam logic [15:0] GAIN_D_RESET         = 16'd12;
   localparam logic [19:0] INTEGRAL_LIMIT_RESET = 20'd40000;
   localparam logic [15:0] DUTY_MAX_RESET       = 16'd4000;

   // Previous error after reset
   localparam logic signed [31:0] PREV_ERROR_RESET = 32'sd14;

   // Divide-by-ten path. A magnitude at or above ten times 2^16 always
   // saturates the 16-bit duty, so only 20 bits go through the reciprocal.
   localparam int          DIV_IN_WIDTH  = 20;
   localparam int          DIV_SHIFT     = 23;
   localparam logic [19:0] DIV_RECIP     = 20'd838861;   // ceil(2^23 / 10)
   localparam logic [51:0] DUTY_SAT_MAG  = 52'd655360;   // 10 * 2^16
   localparam logic [51:0] DRIVE_MIN_MAG = 52'd10;       // smallest nonzero drive

   // Commands
   localparam logic CMD_TICK         = 1'b0;
   localparam logic CMD_SET_VELOCITY = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [31:0]        position;
      logic signed [63:0] velocity;
   } req_type;

   typedef struct packed {
      logic [15:0]        duty;
      logic               drive_left;
      logic               drive_right;
      logic signed [31:0] position_error;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/servo_position_pid_drive_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_position_pid_drive_top: PID position controller with clamped integrator
// Tracks a moving fixed-point setpoint against encoder positions and drives a
// PWM duty plus two direction pins.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one beat per control tick (cmd = tick, encoder position) or
//          per velocity load (cmd = set velocity, signed fixed-point velocity).
//   rsp_*  returns exactly one beat per request beat, in order: duty, the two
//          direction pins and the position error of that tick (zero on a
//          velocity load, which repeats the last duty and pins).
//   csr_*  writes the gains, integrator limit, duty limit and orientation;
//          write only while no request is in flight.
// Timing:
//   A request beat passes the stage 1 to 6 registers and the output register.
//   Throughput is one beat per cycle while the response is not stalled: the
//   feedback loops (setpoint add, integrator add and clamp, pin hold) each
//   close within a single stage; the P and I products share stage 1.
// Reset:
//   Synchronous, active high. Empties the pipeline, loads register defaults,
//   clears setpoint, velocity, integrator and pins, sets previous error to 14.
// Stall:
//   A stalled response holds in the output register; earlier stages keep
//   advancing into empty slots, and req_stall rises only once every stage
//   behind a stalled full output is occupied.
// ----------------------------------------------------------------------------
module servo_position_pid_drive_top #(
   parameter int FRACTION_BITS = spd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire spd_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output spd_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_we,
   input  wire [spd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire [spd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, duty_max_ff;
   logic [19:0] integral_limit_ff;
   logic        reversed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= spd_pkg::GAIN_P_RESET;
         gain_i_ff         <= spd_pkg::GAIN_I_RESET;
         gain_d_ff         <= spd_pkg::GAIN_D_RESET;
         integral_limit_ff <= spd_pkg::INTEGRAL_LIMIT_RESET;
         duty_max_ff       <= spd_pkg::DUTY_MAX_RESET;
         reversed_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            spd_pkg::CSR_GAIN_P:         gain_p_ff         <= csr_wdata[15:0];
            spd_pkg::CSR_GAIN_I:         gain_i_ff         <= csr_wdata[15:0];
            spd_pkg::CSR_GAIN_D:         gain_d_ff         <= csr_wdata[15:0];
            spd_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_wdata;
            spd_pkg::CSR_DUTY_MAX:       duty_max_ff       <= csr_wdata[15:0];
            spd_pkg::CSR_REVERSED:       reversed_ff       <= csr_wdata[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage enables: a stage advances when its next slot is empty or moving
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic rsp_valid_ff;
   logic en0, en1, en2, en3, en4, en5, en6;

   assign en6 = !rsp_valid_ff || !rsp_stall;
   assign en5 = !s6_valid_ff || en6;
   assign en4 = !s5_valid_ff || en5;
   assign en3 = !s4_valid_ff || en4;
   assign en2 = !s3_valid_ff || en3;
   assign en1 = !s2_valid_ff || en2;
   assign en0 = !s1_valid_ff || en1;

   assign req_stall = !en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) s1_valid_ff  <= req_valid;
         if (en1) s2_valid_ff  <= s1_valid_ff;
         if (en2) s3_valid_ff  <= s2_valid_ff;
         if (en3) s4_valid_ff  <= s3_valid_ff;
         if (en4) s5_valid_ff  <= s4_valid_ff;
         if (en5) s6_valid_ff  <= s5_valid_ff;
         if (en6) rsp_valid_ff <= s6_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: setpoint advance and position error
   // ------------------------------------------------------------------
   logic [63:0]        setpoint_ff, setpoint_in;
   logic [63:0]        speed_ff;
   logic [31:0]        last_pos_ff;
   logic [63:0]        sp_next;
   logic               s0_take, s0_tick;
   logic               s1_cmd_ff;
   logic signed [31:0] s1_err_ff, s1_err_in;

   assign s0_take = req_valid && en0;
   assign s0_tick = req_data.cmd == spd_pkg::CMD_TICK;
   assign sp_next = setpoint_ff + speed_ff;

   always_comb begin
      if (s0_tick) begin
         setpoint_in = sp_next;
         s1_err_in   = $signed(sp_next[FRACTION_BITS +: 32] - req_data.position);
      end else begin
         // resync the setpoint to the last seen position
         setpoint_in = 64'(last_pos_ff) << FRACTION_BITS;
         s1_err_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         speed_ff    <= '0;
         last_pos_ff <= '0;
      end else if (s0_take) begin
         setpoint_ff <= setpoint_in;
         if (s0_tick) begin
            last_pos_ff <= req_data.position;
         end else begin
            speed_ff <= req_data.velocity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         s1_cmd_ff <= req_data.cmd;
         s1_err_ff <= s1_err_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: error difference, P and I products
   // ------------------------------------------------------------------
   logic signed [31:0] prev_err_ff;
   logic               s2_cmd_ff;
   logic signed [31:0] s2_err_ff;
   logic signed [32:0] s2_diff_ff, s2_diff_in;
   logic signed [48:0] s2_pp_ff, s2_pp_in, s2_pi_ff, s2_pi_in;
   logic signed [48:0] s1_err_x;

   assign s1_err_x   = {{17{s1_err_ff[31]}}, s1_err_ff};
   assign s2_diff_in = {prev_err_ff[31], prev_err_ff} - {s1_err_ff[31], s1_err_ff};
   assign s2_pp_in   = $signed({33'd0, gain_p_ff}) * s1_err_x;
   assign s2_pi_in   = $signed({33'd0, gain_i_ff}) * s1_err_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= spd_pkg::PREV_ERROR_RESET;
      end else if (en1 && s1_valid_ff && s1_cmd_ff == spd_pkg::CMD_TICK) begin
         prev_err_ff <= s1_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_err_ff  <= s1_err_ff;
         s2_diff_ff <= s2_diff_in;
         s2_pp_ff   <= s2_pp_in;
         s2_pi_ff   <= s2_pi_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: integrator add and clamp, D product
   // ------------------------------------------------------------------
   logic signed [20:0] integral_ff, integral_in;
   logic signed [49:0] isum, lim_pos, lim_neg;
   logic               s3_cmd_ff;
   logic signed [31:0] s3_err_ff;
   logic signed [48:0] s3_pp_ff;
   logic signed [20:0] s3_int_ff;
   logic signed [49:0] s3_pd_ff, s3_pd_in;

   assign isum    = {{29{integral_ff[20]}}, integral_ff} + {s2_pi_ff[48], s2_pi_ff};
   assign lim_pos = $signed({30'd0, integral_limit_ff});
   assign lim_neg = 50'sd0 - lim_pos;

   always_comb begin
      priority if (isum > lim_pos) begin
         integral_in = lim_pos[20:0];
      end else if (isum < lim_neg) begin
         integral_in = lim_neg[20:0];
      end else begin
         integral_in = isum[20:0];
      end
   end

   assign s3_pd_in = $signed({34'd0, gain_d_ff}) * {{17{s2_diff_ff[32]}}, s2_diff_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
      end else if (en2 && s2_valid_ff && s2_cmd_ff == spd_pkg::CMD_TICK) begin
         integral_ff <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s3_cmd_ff <= s2_cmd_ff;
         s3_err_ff <= s2_err_ff;
         s3_pp_ff  <= s2_pp_ff;
         s3_int_ff <= integral_in;
         s3_pd_ff  <= s3_pd_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: sum the three terms
   // ------------------------------------------------------------------
   logic               s4_cmd_ff;
   logic signed [31:0] s4_err_ff;
   logic signed [51:0] s4_act_ff, s4_act_in;

   assign s4_act_in = {{3{s3_pp_ff[48]}}, s3_pp_ff}
                    + {{31{s3_int_ff[20]}}, s3_int_ff}
                    + {{2{s3_pd_ff[49]}}, s3_pd_ff};

   always_ff @(posedge clock) begin
      if (en3) begin
         s4_cmd_ff <= s3_cmd_ff;
         s4_err_ff <= s3_err_ff;
         s4_act_ff <= s4_act_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: magnitude, saturation and nonzero detection
   // ------------------------------------------------------------------
   logic [51:0]        s4_mag;
   logic               s5_cmd_ff, s5_neg_ff, s5_big_ff, s5_nz_ff;
   logic signed [31:0] s5_err_ff;
   logic [spd_pkg::DIV_IN_WIDTH-1:0] s5_x_ff;

   assign s4_mag = s4_act_ff[51] ? (~s4_act_ff + 52'd1) : s4_act_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         s5_cmd_ff <= s4_cmd_ff;
         s5_err_ff <= s4_err_ff;
         s5_neg_ff <= s4_act_ff[51];
         s5_big_ff <= s4_mag >= spd_pkg::DUTY_SAT_MAG;
         s5_nz_ff  <= s4_mag >= spd_pkg::DRIVE_MIN_MAG;
         s5_x_ff   <= s4_mag[spd_pkg::DIV_IN_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: divide by ten through the reciprocal
   // ------------------------------------------------------------------
   logic [39:0]        s5_prod;
   logic               s6_cmd_ff, s6_neg_ff, s6_big_ff, s6_nz_ff;
   logic signed [31:0] s6_err_ff;
   logic [15:0]        s6_q_ff;

   assign s5_prod = {20'd0, s5_x_ff} * {20'd0, spd_pkg::DIV_RECIP};

   always_ff @(posedge clock) begin
      if (en5) begin
         s6_cmd_ff <= s5_cmd_ff;
         s6_err_ff <= s5_err_ff;
         s6_neg_ff <= s5_neg_ff;
         s6_big_ff <= s5_big_ff;
         s6_nz_ff  <= s5_nz_ff;
         s6_q_ff   <= s5_prod[spd_pkg::DIV_SHIFT +: 16];
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: duty limit, direction pins, response register
   // ------------------------------------------------------------------
   logic [1:0]       dir_ff, dir_in;     // bit 0 left, bit 1 right
   logic [15:0]      last_duty_ff, duty_in;
   spd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             s6_tick;

   assign s6_tick = s6_cmd_ff == spd_pkg::CMD_TICK;

   always_comb begin
      // saturate at duty_max
      if (s6_big_ff || s6_q_ff > duty_max_ff) begin
         duty_in = duty_max_ff;
      end else begin
         duty_in = s6_q_ff;
      end
      // zero drive holds the pins
      dir_in = dir_ff;
      if (s6_nz_ff) begin
         dir_in = (s6_neg_ff ^ reversed_ff) ? 2'b10 : 2'b01;
      end
      if (s6_tick) begin
         rsp_data_in.duty        = duty_in;
         rsp_data_in.drive_left  = dir_in[0];
         rsp_data_in.drive_right = dir_in[1];
      end else begin
         rsp_data_in.duty        = last_duty_ff;
         rsp_data_in.drive_left  = dir_ff[0];
         rsp_data_in.drive_right = dir_ff[1];
      end
      rsp_data_in.position_error = s6_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= 2'b00;
         last_duty_ff <= '0;
      end else if (en6 && s6_valid_ff && s6_tick) begin
         dir_ff       <= dir_in;
         last_duty_ff <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en6 && s6_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Input backs up only behind a full, stalled output register
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // Never drive both direction pins
   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.drive_left && rsp_data.drive_right))
      else $error("both direction pins high");

   // A nonzero duty always comes with a direction pin set
   a_duty_has_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.duty != 16'd0) |->
         (rsp_data.drive_left || rsp_data.drive_right))
      else $error("nonzero duty with no direction pin");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
`default_nettype wire
